FILE: rtl/core/itprof_pkg.sv
`timescale 1ns / 1ps
package itprof_pkg;

    localparam int ADDR_BITS    = 16;
    localparam int STACK_DEPTH  = 64;
    localparam int COUNT_BITS   = 32;
    localparam int TIME_BITS    = 48;
    localparam int PC_BITS      = 16;
    localparam int LEN_BITS     = 3;
    localparam int TS_BITS      = 8;
    localparam int KIND_BITS    = 2;
    localparam int SP_BITS      = $clog2(STACK_DEPTH + 1);
    localparam int STK_IDX_BITS = $clog2(STACK_DEPTH);

    localparam logic       MODE_RECORD = 1'b0;
    localparam logic       MODE_READ   = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_OTHER = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_JUMP  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CALL  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_RET   = 2'd3;

    typedef logic [ADDR_BITS-1:0]    t_addr;
    typedef logic [COUNT_BITS-1:0]   t_cnt;
    typedef logic [TIME_BITS-1:0]    t_time;
    typedef logic [SP_BITS-1:0]      t_sp;
    typedef logic [STK_IDX_BITS-1:0] t_stk_idx;

    typedef struct packed {
        logic                 mode;
        logic [PC_BITS-1:0]   pc;
        logic [LEN_BITS-1:0]  instr_len;
        logic [PC_BITS-1:0]   next_pc;
        logic [TS_BITS-1:0]   tstates;
        logic                 is_conditional;
        logic [KIND_BITS-1:0] kind;
        logic                 is_halt;
    } t_in_item;

    typedef struct packed {
        t_cnt  hit_count;
        t_time cycle_sum;
        t_cnt  taken_count;
        t_cnt  not_taken_count;
        t_cnt  callee_count;
        t_time inclusive_sum;
        t_time tick_total;
        t_time idle_total;
        t_sp   stack_level;
        logic  overflowed;
        logic  was_taken;
    } t_out_item;

    // one row of the per-address statistics memory
    typedef struct packed {
        t_cnt  hits;
        t_time cycles;
        t_cnt  taken;
        t_cnt  fallthru;
        t_cnt  calls;
        t_time incl;
    } t_stat_row;

    typedef struct packed {
        logic      re;
        t_addr     raddr;
        logic      we;
        t_addr     waddr;
        t_stat_row wdata;
    } t_stat_req;

    typedef struct packed {
        t_addr target;
        t_time start;
    } t_stk_entry;

    typedef struct packed {
        logic       re;
        t_stk_idx   raddr;
        logic       we;
        t_stk_idx   waddr;
        t_stk_entry wdata;
    } t_stk_req;

    function automatic t_cnt sat_inc(t_cnt a);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + (COUNT_BITS + 1)'(1);
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    function automatic t_time sat_add_time(t_time a, t_time b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/itprof_stat_ram.sv
`timescale 1ns / 1ps
module itprof_stat_ram
    import itprof_pkg::*;
(
    input  logic      i_clk,
    input  t_stat_req i_req,
    output t_stat_row o_rdata
);

    t_stat_row mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule

FILE: rtl/core/itprof_stack_ram.sv
`timescale 1ns / 1ps
module itprof_stack_ram
    import itprof_pkg::*;
(
    input  logic       i_clk,
    input  t_stk_req   i_req,
    output t_stk_entry o_rdata
);

    t_stk_entry mem [STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule

FILE: rtl/core/itprof_ctrl.sv
`timescale 1ns / 1ps
module itprof_ctrl
    import itprof_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    input  logic       i_out_free,
    output logic       o_done,
    output t_out_item  o_result,
    output t_stat_req  o_stat_req,
    input  t_stat_row  i_stat_rdata,
    output t_stk_req   o_stk_req,
    input  t_stk_entry i_stk_rdata
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_STK   = 3'd2;
    localparam logic [2:0] S_AUX   = 3'd3;
    localparam logic [2:0] S_MAIN  = 3'd4;

    logic [2:0] r_state,    n_state;
    t_addr      r_clr_addr, n_clr_addr;
    t_in_item   r_item,     n_item;
    logic       r_taken,    n_taken;
    logic       r_is_call,  n_is_call;
    t_addr      r_aux_addr, n_aux_addr;
    logic       r_fwd,      n_fwd;
    t_stat_row  r_fwd_row,  n_fwd_row;
    t_time      r_dur,      n_dur;
    t_time      r_tick,     n_tick;
    t_time      r_idle,     n_idle;
    t_sp        r_sp,       n_sp;
    logic       r_ovf,      n_ovf;

    logic       in_record;
    logic       in_taken;
    logic [PC_BITS-1:0] in_seq_pc;
    t_addr      in_idx;
    t_addr      in_tgt;
    t_sp        sp_dec;
    t_addr      item_idx;
    t_stat_row  aux_row;
    t_stat_row  cur_row;
    t_stat_row  main_row;
    logic       item_record;

    assign in_record   = (i_in_item.mode == MODE_RECORD);
    assign in_seq_pc   = i_in_item.pc + PC_BITS'(i_in_item.instr_len);
    assign in_taken    = (i_in_item.next_pc != in_seq_pc);
    assign in_idx      = t_addr'(i_in_item.pc);
    assign in_tgt      = t_addr'(i_in_item.next_pc);
    assign sp_dec      = r_sp - SP_BITS'(1);
    assign item_idx    = t_addr'(r_item.pc);
    assign item_record = (r_item.mode == MODE_RECORD);

    // side update: call count at the target, or inclusive time of the popped frame
    always_comb begin
        aux_row = i_stat_rdata;
        if (r_is_call) begin
            aux_row.calls = sat_inc(i_stat_rdata.calls);
        end else begin
            aux_row.incl = sat_add_time(i_stat_rdata.incl, r_dur);
        end
    end

    // main update at the item's own address
    assign cur_row = r_fwd ? r_fwd_row : i_stat_rdata;

    always_comb begin
        main_row = cur_row;
        if (item_record) begin
            main_row.hits   = sat_inc(cur_row.hits);
            main_row.cycles = sat_add_time(cur_row.cycles, t_time'(r_item.tstates));
            if (r_item.is_conditional && (r_item.kind != KIND_OTHER)) begin
                if (r_taken) begin
                    main_row.taken = sat_inc(cur_row.taken);
                end else begin
                    main_row.fallthru = sat_inc(cur_row.fallthru);
                end
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_item     = r_item;
        n_taken    = r_taken;
        n_is_call  = r_is_call;
        n_aux_addr = r_aux_addr;
        n_fwd      = r_fwd;
        n_fwd_row  = r_fwd_row;
        n_dur      = r_dur;
        n_tick     = r_tick;
        n_idle     = r_idle;
        n_sp       = r_sp;
        n_ovf      = r_ovf;
        o_stat_req = '0;
        o_stk_req  = '0;
        o_done     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_stat_req.we    = 1'b1;
                o_stat_req.waddr = r_clr_addr;
                o_stat_req.wdata = '0;
                n_clr_addr       = r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item     = i_in_item;
                    n_taken    = in_record && in_taken;
                    n_is_call  = 1'b0;
                    n_aux_addr = in_tgt;
                    n_fwd      = 1'b0;
                    o_stat_req.re    = 1'b1;
                    o_stat_req.raddr = in_idx;
                    n_state          = S_MAIN;
                    if (in_record) begin
                        n_tick = sat_add_time(r_tick, t_time'(i_in_item.tstates));
                        if (i_in_item.is_halt) begin
                            n_idle = sat_add_time(r_idle, t_time'(i_in_item.tstates));
                        end
                        if (in_taken && (i_in_item.kind == KIND_CALL)) begin
                            n_is_call        = 1'b1;
                            o_stat_req.raddr = in_tgt;
                            n_state          = S_AUX;
                            if (r_sp < SP_BITS'(STACK_DEPTH)) begin
                                o_stk_req.we           = 1'b1;
                                o_stk_req.waddr        = r_sp[STK_IDX_BITS-1:0];
                                o_stk_req.wdata.target = in_tgt;
                                o_stk_req.wdata.start  = r_tick;
                                n_sp                   = r_sp + SP_BITS'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else if (in_taken && (i_in_item.kind == KIND_RET)
                                     && (r_sp != '0)) begin
                            o_stat_req.re   = 1'b0;
                            o_stk_req.re    = 1'b1;
                            o_stk_req.raddr = sp_dec[STK_IDX_BITS-1:0];
                            n_sp            = sp_dec;
                            n_state         = S_STK;
                        end
                    end
                end
            end
            S_STK: begin
                // tick counter already holds the tick after this item
                n_aux_addr = i_stk_rdata.target;
                n_dur      = (r_tick >= i_stk_rdata.start) ? r_tick - i_stk_rdata.start
                                                            : '0;
                o_stat_req.re    = 1'b1;
                o_stat_req.raddr = i_stk_rdata.target;
                n_state          = S_AUX;
            end
            S_AUX: begin
                o_stat_req.we    = 1'b1;
                o_stat_req.waddr = r_aux_addr;
                o_stat_req.wdata = aux_row;
                o_stat_req.re    = 1'b1;
                o_stat_req.raddr = item_idx;
                // the read below misses this write when the addresses match
                n_fwd            = (r_aux_addr == item_idx);
                n_fwd_row        = aux_row;
                n_state          = S_MAIN;
            end
            S_MAIN: begin
                if (i_out_free) begin
                    o_stat_req.we    = item_record;
                    o_stat_req.waddr = item_idx;
                    o_stat_req.wdata = main_row;
                    o_done           = 1'b1;
                    n_fwd            = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_result.hit_count       = main_row.hits;
        o_result.cycle_sum       = main_row.cycles;
        o_result.taken_count     = main_row.taken;
        o_result.not_taken_count = main_row.fallthru;
        o_result.callee_count    = main_row.calls;
        o_result.inclusive_sum   = main_row.incl;
        o_result.tick_total      = r_tick;
        o_result.idle_total      = r_idle;
        o_result.stack_level     = r_sp;
        o_result.overflowed      = r_ovf;
        o_result.was_taken       = r_taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_fwd      <= 1'b0;
            r_tick     <= '0;
            r_idle     <= '0;
            r_sp       <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_fwd      <= n_fwd;
            r_tick     <= n_tick;
            r_idle     <= n_idle;
            r_sp       <= n_sp;
            r_ovf      <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_taken    <= n_taken;
        r_is_call  <= n_is_call;
        r_aux_addr <= n_aux_addr;
        r_fwd_row  <= n_fwd_row;
        r_dur      <= n_dur;
    end

`ifndef NO_ASSERTIONS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_BITS'(STACK_DEPTH))
        else $error("return stack level beyond depth");

    a_idle_le_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle <= r_tick)
        else $error("idle total exceeds tick total");

    a_tick_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_tick >= $past(r_tick))
        else $error("tick total went backwards");

    a_fwd_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_state == S_MAIN)
        else $error("forwarded row held outside the final update");

    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> i_out_free)
        else $error("result produced while output register is busy");
`endif

endmodule

FILE: rtl/core/instruction_trace_profiler.sv
`timescale 1ns / 1ps
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+------------------------
// input    | i_in_valid  | o_in_ready  | i_in_item  (t_in_item)
// output   | o_out_valid | i_out_ready | o_out_item (t_out_item)
//
// an item passes S_IDLE and S_MAIN, a taken call adds S_AUX, and a taken
// return with a frame on the stack adds S_STK (the stack read) and S_AUX,
// a read-modify-write turn of the single-port-write statistics memory
// after reset a clearing pass zeroes all 65536 rows, one per cycle, and no
// item is accepted until it is done
// a finished result sits in the output register; the next item is accepted
// meanwhile and holds in its final cycle until that register is taken
module instruction_trace_profiler
    import itprof_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_stat_req  stat_req;
    t_stat_row  stat_rdata;
    t_stk_req   stk_req;
    t_stk_entry stk_rdata;
    logic       done;
    t_out_item  result;
    logic       out_free;

    logic       r_out_valid;
    t_out_item  r_out_item;

    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || i_out_ready;

    // per-address statistics: hits, ticks, branch counts, calls, inclusive time
    itprof_stat_ram u_stat_ram (
        .i_clk   (i_clk),
        .i_req   (stat_req),
        .o_rdata (stat_rdata)
    );

    // return stack frames: call target and start tick
    itprof_stack_ram u_stack_ram (
        .i_clk   (i_clk),
        .i_req   (stk_req),
        .o_rdata (stk_rdata)
    );

    // sequencer: clearing pass, stack push and pop, table updates, totals
    itprof_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_free   (out_free),
        .o_done       (done),
        .o_result     (result),
        .o_stat_req   (stat_req),
        .i_stat_rdata (stat_rdata),
        .o_stk_req    (stk_req),
        .i_stk_rdata  (stk_rdata)
    );

    // output item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
